[hdl/lfrm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lfrm_pkg;

   // Field widths
   localparam int COORD_W    = 16;
   localparam int ANGLE_W    = 9;
   localparam int MAX_FACES  = 10;
   localparam int FACE_CNT_W = 4;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = COORD_W;

   // Arithmetic widths
   localparam int MUL_A_W = COORD_W + 1;          // box size is one bit wider
   localparam int PROD_W  = MUL_A_W + COORD_W;
   localparam int NUM_W   = PROD_W + 1;           // doubled product plus divisor
   localparam int DIV_W   = COORD_W + 1;          // doubled crop width
   localparam int AREA_W  = 2 * COORD_W;
   localparam int STEP_W  = $clog2(COORD_W);

   localparam logic [COORD_W-1:0] COORD_MAX = '1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CROP_LEFT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CROP_TOP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CROP_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CROP_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_ANGLE   = 3'd6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_LOAD,
      S_DIV,
      S_STORE,
      S_AREA,
      S_CMP,
      S_EMIT
   } state_type;

   // Divisions done per face, in order
   typedef enum logic [2:0] {
      OP_Q,    // crop_width * out_height / out_width
      OP_T,    // mapped top
      OP_L,    // mapped left
      OP_W,    // mapped width
      OP_H     // mapped height
   } op_type;

   typedef struct packed {
      logic   accept;
      logic   mul;
      logic   load;
      logic   step;
      logic   store;
      logic   area;
      logic   update;
      logic   emit;
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic consider;
      logic req_last;
      logic item_last;
      logic div_last;
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

[hdl/lfrm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfrm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire lfrm_pkg::dp_sts_type sts,
   output lfrm_pkg::dp_cmd_type      cmd
);

   lfrm_pkg::state_type state_ff, state_in;
   lfrm_pkg::op_type    op_ff, op_in;

   // Take a word only while idle
   assign req_stall = (state_ff != lfrm_pkg::S_IDLE);

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfrm_pkg::S_IDLE;
         op_ff    <= lfrm_pkg::OP_Q;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         lfrm_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in = lfrm_pkg::OP_Q;
               if (sts.consider) begin
                  state_in = lfrm_pkg::S_MUL;
               end else if (sts.req_last) begin
                  state_in = lfrm_pkg::S_EMIT;
               end
            end
         end
         lfrm_pkg::S_MUL:  state_in = lfrm_pkg::S_LOAD;
         lfrm_pkg::S_LOAD: state_in = lfrm_pkg::S_DIV;
         lfrm_pkg::S_DIV: begin
            if (sts.div_last) begin
               state_in = lfrm_pkg::S_STORE;
            end
         end
         lfrm_pkg::S_STORE: begin
            unique case (op_ff)
               lfrm_pkg::OP_Q: begin
                  op_in    = lfrm_pkg::OP_T;
                  state_in = lfrm_pkg::S_MUL;
               end
               lfrm_pkg::OP_T: begin
                  op_in    = lfrm_pkg::OP_L;
                  state_in = lfrm_pkg::S_MUL;
               end
               lfrm_pkg::OP_L: begin
                  op_in    = lfrm_pkg::OP_W;
                  state_in = lfrm_pkg::S_MUL;
               end
               lfrm_pkg::OP_W: begin
                  op_in    = lfrm_pkg::OP_H;
                  state_in = lfrm_pkg::S_MUL;
               end
               default: state_in = lfrm_pkg::S_AREA;
            endcase
         end
         lfrm_pkg::S_AREA: state_in = lfrm_pkg::S_CMP;
         lfrm_pkg::S_CMP: begin
            state_in = sts.item_last ? lfrm_pkg::S_EMIT : lfrm_pkg::S_IDLE;
         end
         lfrm_pkg::S_EMIT: begin
            if (sts.out_free) begin
               state_in = lfrm_pkg::S_IDLE;
            end
         end
         default: state_in = lfrm_pkg::S_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd    = '0;
      cmd.op = op_ff;
      unique case (state_ff)
         lfrm_pkg::S_IDLE:  cmd.accept = req_valid;
         lfrm_pkg::S_MUL:   cmd.mul    = 1'b1;
         lfrm_pkg::S_LOAD:  cmd.load   = 1'b1;
         lfrm_pkg::S_DIV:   cmd.step   = 1'b1;
         lfrm_pkg::S_STORE: cmd.store  = 1'b1;
         lfrm_pkg::S_AREA:  cmd.area   = 1'b1;
         lfrm_pkg::S_CMP:   cmd.update = 1'b1;
         lfrm_pkg::S_EMIT:  cmd.emit   = sts.out_free;
         default: ;
      endcase
   end

   // A face that needs mapping always starts with the letterbox division
   a_start_map: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lfrm_pkg::S_IDLE && req_valid && sts.consider)
      |=> (state_ff == lfrm_pkg::S_MUL && op_ff == lfrm_pkg::OP_Q))
      else $error("mapping did not start with the letterbox division");

endmodule

`default_nettype wire

[hdl/lfrm_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfrm_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire lfrm_pkg::dp_cmd_type                   cmd,
   output lfrm_pkg::dp_sts_type                        sts,
   // configuration
   input  wire logic                                   csr_we,
   input  wire logic [lfrm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [lfrm_pkg::CSR_DATA_W-1:0]        csr_wdata,
   // input word
   input  wire logic [lfrm_pkg::COORD_W-1:0]           req_face_x_min,
   input  wire logic [lfrm_pkg::COORD_W-1:0]           req_face_y_min,
   input  wire logic [lfrm_pkg::COORD_W-1:0]           req_face_x_max,
   input  wire logic [lfrm_pkg::COORD_W-1:0]           req_face_y_max,
   input  wire logic                                   req_face_valid,
   input  wire logic                                   req_last_face,
   // result word
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [lfrm_pkg::COORD_W-1:0]                rsp_best_x,
   output logic [lfrm_pkg::COORD_W-1:0]                rsp_best_y,
   output logic [lfrm_pkg::COORD_W-1:0]                rsp_best_w,
   output logic [lfrm_pkg::COORD_W-1:0]                rsp_best_h,
   output logic [lfrm_pkg::ANGLE_W-1:0]                rsp_best_angle,
   output logic [lfrm_pkg::COORD_W-1:0]                rsp_center_x,
   output logic [lfrm_pkg::COORD_W-1:0]                rsp_center_y,
   output logic                                        rsp_face_found
);

   localparam int CW = lfrm_pkg::COORD_W;
   localparam logic [lfrm_pkg::MUL_A_W-1:0] MUL_A_ONE = lfrm_pkg::MUL_A_W'(1);

   // Configuration registers
   logic [CW-1:0]                crop_left_ff, crop_top_ff, crop_width_ff, crop_height_ff;
   logic [CW-1:0]                out_width_ff, out_height_ff;
   logic [lfrm_pkg::ANGLE_W-1:0] rot_angle_ff;

   // Current face
   logic [CW-1:0]                l_ff, t_ff, l_in, t_in;
   logic [lfrm_pkg::MUL_A_W-1:0] rw_ff, rh_ff;
   logic                         last_ff;

   // Per-face results
   logic [CW-1:0] off_ff, mt_ff, ml_ff, mw_ff, mh_ff, off_in;

   // Multiplier and divider
   logic [lfrm_pkg::MUL_A_W-1:0] mul_a;
   logic [CW-1:0]                mul_b, t_diff;
   logic [lfrm_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [lfrm_pkg::NUM_W-1:0]   num;
   logic [lfrm_pkg::DIV_W-1:0]   dvs, div_ff, rem_ff, rem_in;
   logic [CW-1:0]                low_ff, low_in, quot;
   logic [lfrm_pkg::DIV_W:0]     rem2, rem_sub;
   logic                         ge, sat_ff;
   logic [lfrm_pkg::STEP_W-1:0]  cnt_ff;

   // Frame state
   logic [lfrm_pkg::AREA_W-1:0]     best_area_ff;
   logic [CW-1:0]                   best_left_ff, best_top_ff, best_width_ff, best_height_ff;
   logic [lfrm_pkg::FACE_CNT_W-1:0] faces_seen_ff;

   // Result staging
   logic [CW:0]   cx, cy;
   logic          fallback, found;
   logic          regs_ok, count_ok, inverted;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         crop_left_ff   <= '0;
         crop_top_ff    <= '0;
         crop_width_ff  <= CW'(1);
         crop_height_ff <= CW'(1);
         out_width_ff   <= CW'(1);
         out_height_ff  <= CW'(1);
         rot_angle_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            lfrm_pkg::CSR_CROP_LEFT:   crop_left_ff   <= csr_wdata[CW-1:0];
            lfrm_pkg::CSR_CROP_TOP:    crop_top_ff    <= csr_wdata[CW-1:0];
            lfrm_pkg::CSR_CROP_WIDTH:  crop_width_ff  <= csr_wdata[CW-1:0];
            lfrm_pkg::CSR_CROP_HEIGHT: crop_height_ff <= csr_wdata[CW-1:0];
            lfrm_pkg::CSR_OUT_WIDTH:   out_width_ff   <= csr_wdata[CW-1:0];
            lfrm_pkg::CSR_OUT_HEIGHT:  out_height_ff  <= csr_wdata[CW-1:0];
            lfrm_pkg::CSR_ROT_ANGLE:   rot_angle_ff   <= csr_wdata[lfrm_pkg::ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // Qualify the incoming word
   assign regs_ok  = (crop_width_ff != '0) && (crop_height_ff != '0) &&
                     (out_width_ff != '0) && (out_height_ff != '0);
   assign count_ok = req_face_valid &&
                     (faces_seen_ff < lfrm_pkg::FACE_CNT_W'(lfrm_pkg::MAX_FACES));
   assign inverted = (req_face_x_max < req_face_x_min) || (req_face_y_max < req_face_y_min);

   assign sts.consider  = count_ok && !inverted && regs_ok;
   assign sts.req_last  = req_last_face;
   assign sts.item_last = last_ff;
   assign sts.div_last  = (cnt_ff == lfrm_pkg::STEP_W'(CW - 1));
   assign sts.out_free  = !rsp_valid || !rsp_stall;

   // Clamp the box origin to the crop region
   assign l_in = (req_face_x_min > crop_left_ff) ? req_face_x_min - crop_left_ff : '0;
   assign t_in = (req_face_y_min > crop_top_ff) ? req_face_y_min - crop_top_ff : '0;

   // Capture the face
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         l_ff    <= l_in;
         t_ff    <= t_in;
         rw_ff   <= {1'b0, req_face_x_max} - {1'b0, req_face_x_min} + MUL_A_ONE;
         rh_ff   <= {1'b0, req_face_y_max} - {1'b0, req_face_y_min} + MUL_A_ONE;
         last_ff <= req_last_face;
      end
   end

   // Remove the letterbox offset; a top above it maps to zero
   assign t_diff = (t_ff > off_ff) ? t_ff - off_ff : '0;

   // Select multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = out_width_ff;
      if (cmd.area) begin
         mul_a = {1'b0, mw_ff};
         mul_b = mh_ff;
      end else begin
         unique case (cmd.op)
            lfrm_pkg::OP_Q: begin
               mul_a = {1'b0, crop_width_ff};
               mul_b = out_height_ff;
            end
            lfrm_pkg::OP_T: mul_a = {1'b0, t_diff};
            lfrm_pkg::OP_L: mul_a = {1'b0, l_ff};
            lfrm_pkg::OP_W: mul_a = rw_ff;
            lfrm_pkg::OP_H: mul_a = rh_ff;
            default: mul_a = '0;
         endcase
      end
   end

   assign prod_in = lfrm_pkg::PROD_W'(mul_a) * lfrm_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.mul || cmd.area) begin
         prod_ff <= prod_in;
      end
   end

   // Form dividend and divisor; rounded ops use (2*L*s + c) / (2*c)
   always_comb begin
      case (cmd.op) inside
         lfrm_pkg::OP_Q: begin
            num = lfrm_pkg::NUM_W'(prod_ff);
            dvs = lfrm_pkg::DIV_W'(out_width_ff);
         end
         lfrm_pkg::OP_T, lfrm_pkg::OP_L: begin
            num = {prod_ff, 1'b0} + lfrm_pkg::NUM_W'(crop_width_ff);
            dvs = {crop_width_ff, 1'b0};
         end
         default: begin
            num = lfrm_pkg::NUM_W'(prod_ff);
            dvs = lfrm_pkg::DIV_W'(crop_width_ff);
         end
      endcase
   end

   // One restoring step: shift in a dividend bit, subtract when it fits
   assign rem2    = {rem_ff, low_ff[CW-1]};
   assign rem_sub = rem2 - {1'b0, div_ff};
   assign ge      = (rem2 >= {1'b0, div_ff});
   assign rem_in  = ge ? rem_sub[lfrm_pkg::DIV_W-1:0] : rem2[lfrm_pkg::DIV_W-1:0];
   assign low_in  = {low_ff[CW-2:0], ge};

   // Divider registers; a quotient past the coordinate range saturates
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         div_ff <= dvs;
         sat_ff <= (num[lfrm_pkg::NUM_W-1:CW] >= {1'b0, dvs});
         rem_ff <= num[CW+lfrm_pkg::DIV_W-1:CW];
         low_ff <= num[CW-1:0];
         cnt_ff <= '0;
      end else if (cmd.step) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         cnt_ff <= cnt_ff + lfrm_pkg::STEP_W'(1);
      end
   end

   assign quot   = sat_ff ? lfrm_pkg::COORD_MAX : low_ff;
   assign off_in = (crop_height_ff > quot) ? ((crop_height_ff - quot) >> 1) : '0;

   // Store each quotient where it belongs; sizes are forced even
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         unique case (cmd.op)
            lfrm_pkg::OP_Q: off_ff <= off_in;
            lfrm_pkg::OP_T: mt_ff  <= quot;
            lfrm_pkg::OP_L: ml_ff  <= quot;
            lfrm_pkg::OP_W: mw_ff  <= {quot[CW-1:1], 1'b0};
            lfrm_pkg::OP_H: mh_ff  <= {quot[CW-1:1], 1'b0};
            default: ;
         endcase
      end
   end

   // Keep the largest box of the frame; ties keep the earlier one
   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         best_area_ff   <= '0;
         best_left_ff   <= '0;
         best_top_ff    <= '0;
         best_width_ff  <= '0;
         best_height_ff <= '0;
         faces_seen_ff  <= '0;
      end else begin
         if (cmd.accept && count_ok) begin
            faces_seen_ff <= faces_seen_ff + lfrm_pkg::FACE_CNT_W'(1);
         end
         if (cmd.update && (prod_ff[lfrm_pkg::AREA_W-1:0] > best_area_ff)) begin
            best_area_ff   <= prod_ff[lfrm_pkg::AREA_W-1:0];
            best_left_ff   <= ml_ff;
            best_top_ff    <= mt_ff;
            best_width_ff  <= mw_ff;
            best_height_ff <= mh_ff;
         end
      end
   end

   // Box center with fallback to the middle of the output
   assign cx       = {1'b0, best_left_ff} + {2'b00, best_width_ff[CW-1:1]};
   assign cy       = {1'b0, best_top_ff} + {2'b00, best_height_ff[CW-1:1]};
   assign fallback = (cx == '0) || (cy == '0) ||
                     (cx > {1'b0, out_width_ff}) || (cy > {1'b0, out_height_ff});
   assign found    = (best_area_ff != '0);

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_best_x     <= best_left_ff;
         rsp_best_y     <= best_top_ff;
         rsp_best_w     <= best_width_ff;
         rsp_best_h     <= best_height_ff;
         rsp_best_angle <= found ? rot_angle_ff : '0;
         rsp_center_x   <= fallback ? (out_width_ff >> 1) : cx[CW-1:0];
         rsp_center_y   <= fallback ? (out_height_ff >> 1) : cy[CW-1:0];
         rsp_face_found <= found;
      end
   end

   a_even_size: assert property (@(posedge clock) disable iff (reset)
      (best_width_ff[0] == 1'b0) && (best_height_ff[0] == 1'b0))
      else $error("kept box has an odd size");

   a_area_match: assert property (@(posedge clock) disable iff (reset)
      (best_area_ff != '0) == ((best_width_ff != '0) && (best_height_ff != '0)))
      else $error("kept area disagrees with kept size");

   a_face_limit: assert property (@(posedge clock) disable iff (reset)
      faces_seen_ff <= lfrm_pkg::FACE_CNT_W'(lfrm_pkg::MAX_FACES))
      else $error("face count passed its limit");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp_valid && (best_area_ff == '0) && (faces_seen_ff == '0)))
      else $error("result not posted or frame not cleared");

endmodule

`default_nettype wire

[hdl/largest_face_rect_mapper.sv]
`timescale 1ns / 1ps
`default_nettype none

// A face that is mapped runs five divisions before the next word is taken, each a multiply,
// a load, 16 steps of the shared radix-2 divider and a store, then an area multiply and a
// compare. A skipped word (no face, past the face limit, inverted box or zero size register)
// needs no division; the word that ends the frame then posts the result once the output is
// free, and the result appears in the next cycle and then waits in an output register.
// Synchronous reset restores register defaults, clears the frame and drops rsp_valid.
module largest_face_rect_mapper (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration
   input  wire logic                                  csr_we,
   input  wire logic [lfrm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [lfrm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // input channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [lfrm_pkg::COORD_W-1:0]          req_face_x_min,
   input  wire logic [lfrm_pkg::COORD_W-1:0]          req_face_y_min,
   input  wire logic [lfrm_pkg::COORD_W-1:0]          req_face_x_max,
   input  wire logic [lfrm_pkg::COORD_W-1:0]          req_face_y_max,
   input  wire logic                                  req_face_valid,
   input  wire logic                                  req_last_face,
   // result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [lfrm_pkg::COORD_W-1:0]               rsp_best_x,
   output logic [lfrm_pkg::COORD_W-1:0]               rsp_best_y,
   output logic [lfrm_pkg::COORD_W-1:0]               rsp_best_w,
   output logic [lfrm_pkg::COORD_W-1:0]               rsp_best_h,
   output logic [lfrm_pkg::ANGLE_W-1:0]               rsp_best_angle,
   output logic [lfrm_pkg::COORD_W-1:0]               rsp_center_x,
   output logic [lfrm_pkg::COORD_W-1:0]               rsp_center_y,
   output logic                                       rsp_face_found
);

   lfrm_pkg::dp_cmd_type cmd;
   lfrm_pkg::dp_sts_type sts;

   // Sequence the divisions for each face
   lfrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Map boxes and keep the largest
   lfrm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_face_x_min (req_face_x_min),
      .req_face_y_min (req_face_y_min),
      .req_face_x_max (req_face_x_max),
      .req_face_y_max (req_face_y_max),
      .req_face_valid (req_face_valid),
      .req_last_face  (req_last_face),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_x     (rsp_best_x),
      .rsp_best_y     (rsp_best_y),
      .rsp_best_w     (rsp_best_w),
      .rsp_best_h     (rsp_best_h),
      .rsp_best_angle (rsp_best_angle),
      .rsp_center_x   (rsp_center_x),
      .rsp_center_y   (rsp_center_y),
      .rsp_face_found (rsp_face_found)
   );

endmodule

`default_nettype wire

[sim/face_frame_checker.sv]
`timescale 1ns / 1ps

// Watches the configuration port and both word channels of the face mapper,
// keeps its own copy of the registers and of the running frame, and compares
// every result word with the oldest frame outcome still owed.
module face_frame_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [lfrm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lfrm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic [lfrm_pkg::COORD_W-1:0]          req_face_x_min,
   input  logic [lfrm_pkg::COORD_W-1:0]          req_face_y_min,
   input  logic [lfrm_pkg::COORD_W-1:0]          req_face_x_max,
   input  logic [lfrm_pkg::COORD_W-1:0]          req_face_y_max,
   input  logic                                  req_face_valid,
   input  logic                                  req_last_face,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [lfrm_pkg::COORD_W-1:0]          rsp_best_x,
   input  logic [lfrm_pkg::COORD_W-1:0]          rsp_best_y,
   input  logic [lfrm_pkg::COORD_W-1:0]          rsp_best_w,
   input  logic [lfrm_pkg::COORD_W-1:0]          rsp_best_h,
   input  logic [lfrm_pkg::ANGLE_W-1:0]          rsp_best_angle,
   input  logic [lfrm_pkg::COORD_W-1:0]          rsp_center_x,
   input  logic [lfrm_pkg::COORD_W-1:0]          rsp_center_y,
   input  logic                                  rsp_face_found,
   output int                                    fail_count,
   output int                                    pending_frames
);
   import lfrm_pkg::*;

   localparam logic [63:0] COORD_TOP = (64'd1 << COORD_W) - 64'd1;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      logic [ANGLE_W-1:0] angle;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic               found;
   } frame_outcome_t;

   // register copy
   logic [COORD_W-1:0] crop_left_q, crop_top_q, crop_width_q, crop_height_q;
   logic [COORD_W-1:0] out_width_q, out_height_q;
   logic [ANGLE_W-1:0] angle_q;

   // running frame: largest mapped box so far
   logic [AREA_W-1:0]     keep_area;
   logic [COORD_W-1:0]    keep_left, keep_top, keep_width, keep_height;
   logic [FACE_CNT_W-1:0] faces_counted;

   frame_outcome_t owed_frames [$];

   function automatic logic [63:0] sat_coord(input logic [63:0] v);
      return (v > COORD_TOP) ? COORD_TOP : v;
   endfunction

   function automatic void clear_frame();
      keep_area = '0;
      keep_left = '0;
      keep_top = '0;
      keep_width = '0;
      keep_height = '0;
      faces_counted = '0;
   endfunction

   // Map one face box into output space and keep it if strictly larger.
   function automatic void fold_face(input logic [COORD_W-1:0] xmin, ymin, xmax, ymax);
      logic [63:0] xa, ya, xb, yb, s, c, rw, rh, l, t, q, off, ml, mt, mw, mh, area;
      if (xmax < xmin || ymax < ymin)
         return;
      if (crop_width_q == 0 || crop_height_q == 0 || out_width_q == 0 || out_height_q == 0)
         return;
      xa = xmin;
      ya = ymin;
      xb = xmax;
      yb = ymax;
      s = out_width_q;
      c = crop_width_q;
      rw = xb - xa + 64'd1;
      rh = yb - ya + 64'd1;
      l = (xa > crop_left_q) ? xa - crop_left_q : 64'd0;
      t = (ya > crop_top_q) ? ya - crop_top_q : 64'd0;

      // centered letterbox band to strip from the top
      q = (c * out_height_q) / s;
      off = (crop_height_q > q) ? (crop_height_q - q) / 64'd2 : 64'd0;

      mt = (t > off) ? sat_coord((64'd2 * (t - off) * s + c) / (64'd2 * c)) : 64'd0;
      ml = sat_coord((64'd2 * l * s + c) / (64'd2 * c));
      mw = sat_coord((rw * s) / c) & ~64'd1;
      mh = sat_coord((rh * s) / c) & ~64'd1;

      area = mw * mh;
      if (area > 64'hFFFF_FFFF)
         area = 64'hFFFF_FFFF;
      if (area > keep_area) begin
         keep_area = area[AREA_W-1:0];
         keep_left = ml[COORD_W-1:0];
         keep_top = mt[COORD_W-1:0];
         keep_width = mw[COORD_W-1:0];
         keep_height = mh[COORD_W-1:0];
      end
   endfunction

   // Build the frame outcome, falling back to the output middle when the
   // box center is off the image, then start a fresh frame.
   function automatic frame_outcome_t close_frame();
      frame_outcome_t r;
      logic [31:0] cx, cy;
      r.found = (keep_area != 0);
      cx = keep_left + keep_width / 2;
      cy = keep_top + keep_height / 2;
      if (cx == 0 || cy == 0 || cx > out_width_q || cy > out_height_q) begin
         cx = out_width_q / 2;
         cy = out_height_q / 2;
      end
      r.x = keep_left;
      r.y = keep_top;
      r.w = keep_width;
      r.h = keep_height;
      r.angle = r.found ? angle_q : '0;
      r.cx = cx[COORD_W-1:0];
      r.cy = cy[COORD_W-1:0];
      clear_frame();
      return r;
   endfunction

   function automatic int check_field(input string name, input logic [31:0] want, got);
      if (want === got)
         return 0;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      int errs;
      frame_outcome_t want;
      errs = 0;
      if (reset) begin
         crop_left_q = '0;
         crop_top_q = '0;
         crop_width_q = 1;
         crop_height_q = 1;
         out_width_q = 1;
         out_height_q = 1;
         angle_q = '0;
         clear_frame();
         owed_frames.delete();
         fail_count <= 0;
         pending_frames <= 0;
      end else begin
         // track register writes
         if (csr_we) begin
            case (csr_index)
               CSR_CROP_LEFT: crop_left_q = csr_wdata;
               CSR_CROP_TOP: crop_top_q = csr_wdata;
               CSR_CROP_WIDTH: crop_width_q = csr_wdata;
               CSR_CROP_HEIGHT: crop_height_q = csr_wdata;
               CSR_OUT_WIDTH: out_width_q = csr_wdata;
               CSR_OUT_HEIGHT: out_height_q = csr_wdata;
               CSR_ROT_ANGLE: angle_q = csr_wdata[ANGLE_W-1:0];
               default: ;
            endcase
         end

         // fold an accepted face word; a last mark owes one outcome
         if (req_valid && !req_stall) begin
            if (req_face_valid && faces_counted < MAX_FACES) begin
               faces_counted = faces_counted + 1'b1;
               fold_face(req_face_x_min, req_face_y_min, req_face_x_max, req_face_y_max);
            end
            if (req_last_face)
               owed_frames.push_back(close_frame());
         end

         // compare an accepted result word with the oldest owed outcome
         if (rsp_valid && !rsp_stall) begin
            if (owed_frames.size() == 0) begin
               $display("%0t: result word with no frame owed: x=%0d y=%0d w=%0d h=%0d",
                        $time, rsp_best_x, rsp_best_y, rsp_best_w, rsp_best_h);
               errs = 1;
            end else begin
               want = owed_frames.pop_front();
               errs += check_field("best_x", want.x, rsp_best_x);
               errs += check_field("best_y", want.y, rsp_best_y);
               errs += check_field("best_w", want.w, rsp_best_w);
               errs += check_field("best_h", want.h, rsp_best_h);
               errs += check_field("best_angle", want.angle, rsp_best_angle);
               errs += check_field("center_x", want.cx, rsp_center_x);
               errs += check_field("center_y", want.cy, rsp_center_y);
               errs += check_field("face_found", want.found, rsp_face_found);
            end
         end

         pending_frames <= owed_frames.size();
         fail_count <= fail_count + errs;
      end
   end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
   import lfrm_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 120;

   typedef struct {
      logic [CSR_DATA_W-1:0] crop_left;
      logic [CSR_DATA_W-1:0] crop_top;
      logic [CSR_DATA_W-1:0] crop_width;
      logic [CSR_DATA_W-1:0] crop_height;
      logic [CSR_DATA_W-1:0] out_width;
      logic [CSR_DATA_W-1:0] out_height;
      logic [CSR_DATA_W-1:0] angle;
   } reg_set_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [COORD_W-1:0] req_face_x_min = '0;
   logic [COORD_W-1:0] req_face_y_min = '0;
   logic [COORD_W-1:0] req_face_x_max = '0;
   logic [COORD_W-1:0] req_face_y_max = '0;
   logic               req_face_valid = 1'b0;
   logic               req_last_face = 1'b0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [COORD_W-1:0] rsp_best_x, rsp_best_y, rsp_best_w, rsp_best_h;
   logic [ANGLE_W-1:0] rsp_best_angle;
   logic [COORD_W-1:0] rsp_center_x, rsp_center_y;
   logic               rsp_face_found;

   int fail_count;
   int pending_frames;
   int quiet_cycles = 0;
   int take_hold = 0;
   bit send_quiet = 1'b0;
   bit take_quiet = 1'b0;
   reg_set_t cur_regs;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   largest_face_rect_mapper uut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_face_x_min (req_face_x_min),
      .req_face_y_min (req_face_y_min),
      .req_face_x_max (req_face_x_max),
      .req_face_y_max (req_face_y_max),
      .req_face_valid (req_face_valid),
      .req_last_face  (req_last_face),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_x     (rsp_best_x),
      .rsp_best_y     (rsp_best_y),
      .rsp_best_w     (rsp_best_w),
      .rsp_best_h     (rsp_best_h),
      .rsp_best_angle (rsp_best_angle),
      .rsp_center_x   (rsp_center_x),
      .rsp_center_y   (rsp_center_y),
      .rsp_face_found (rsp_face_found)
   );

   face_frame_checker frame_check (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_face_x_min (req_face_x_min),
      .req_face_y_min (req_face_y_min),
      .req_face_x_max (req_face_x_max),
      .req_face_y_max (req_face_y_max),
      .req_face_valid (req_face_valid),
      .req_last_face  (req_last_face),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_x     (rsp_best_x),
      .rsp_best_y     (rsp_best_y),
      .rsp_best_w     (rsp_best_w),
      .rsp_best_h     (rsp_best_h),
      .rsp_best_angle (rsp_best_angle),
      .rsp_center_x   (rsp_center_x),
      .rsp_center_y   (rsp_center_y),
      .rsp_face_found (rsp_face_found),
      .fail_count     (fail_count),
      .pending_frames (pending_frames)
   );

   // Hold off result words for a random count after each one taken,
   // with occasional stretches of no stall at all.
   always @(posedge clock) begin
      if (reset) begin
         take_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if ($urandom_range(0, 39) == 0)
               take_quiet = !take_quiet;
            take_hold = take_quiet ? 0 : $urandom_range(0, 11);
         end else if (take_hold != 0) begin
            take_hold = take_hold - 1;
         end
         rsp_stall <= (take_hold != 0);
      end
   end

   // Drop the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic drive_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_regs(input reg_set_t regs);
      cur_regs = regs;
      drive_reg(CSR_CROP_LEFT, regs.crop_left);
      drive_reg(CSR_CROP_TOP, regs.crop_top);
      drive_reg(CSR_CROP_WIDTH, regs.crop_width);
      drive_reg(CSR_CROP_HEIGHT, regs.crop_height);
      drive_reg(CSR_OUT_WIDTH, regs.out_width);
      drive_reg(CSR_OUT_HEIGHT, regs.out_height);
      drive_reg(CSR_ROT_ANGLE, regs.angle);
      csr_we <= 1'b0;
   endtask

   // Offer one word after a random gap and hold it until taken.
   task automatic send_word(input logic [COORD_W-1:0] xmin, ymin, xmax, ymax,
                            input logic face_valid, last_face);
      int gap;
      if ($urandom_range(0, 39) == 0)
         send_quiet = !send_quiet;
      gap = send_quiet ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_face_x_min <= xmin;
      req_face_y_min <= ymin;
      req_face_x_max <= xmax;
      req_face_y_max <= ymax;
      req_face_valid <= face_valid;
      req_last_face <= last_face;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   // Drop valid, wait for every owed result, then let the block go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_frames != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COORD_W-1:0] fit_coord(input int v);
      if (v < 0)
         return '0;
      if (v > 65535)
         return '1;
      return v[COORD_W-1:0];
   endfunction

   // Mostly boxes around the crop window, some fully random or inverted.
   task automatic pick_box(output logic [COORD_W-1:0] xmin, ymin, xmax, ymax);
      int span_x, span_y, x0, y0, x1, y1, r;
      logic [COORD_W-1:0] tmp;
      span_x = (cur_regs.crop_width == 0) ? 2048 : int'(cur_regs.crop_width);
      span_y = (cur_regs.crop_height == 0) ? 2048 : int'(cur_regs.crop_height);
      r = $urandom_range(0, 99);
      if (r < 8) begin
         xmin = $urandom;
         ymin = $urandom;
         xmax = $urandom;
         ymax = $urandom;
      end else begin
         x0 = int'(cur_regs.crop_left) - int'($urandom_range(0, span_x / 8))
              + int'($urandom_range(0, span_x));
         y0 = int'(cur_regs.crop_top) - int'($urandom_range(0, span_y / 8))
              + int'($urandom_range(0, span_y));
         x1 = x0 + int'($urandom_range(0, span_x / 2));
         y1 = y0 + int'($urandom_range(0, span_y / 2));
         xmin = fit_coord(x0);
         ymin = fit_coord(y0);
         xmax = fit_coord(x1);
         ymax = fit_coord(y1);
         // invert a few boxes
         if (r < 14) begin
            tmp = xmin;
            xmin = xmax;
            xmax = tmp;
         end else if (r < 18) begin
            tmp = ymin;
            ymin = ymax;
            ymax = tmp;
         end
      end
   endtask

   // One frame: a few faces, sometimes more than the face limit, stray
   // empty words inside, and sometimes an empty word to close it.
   task automatic send_random_frame(output int counted);
      int n_faces;
      bit empty_close;
      logic [COORD_W-1:0] xmin, ymin, xmax, ymax;
      counted = 0;
      n_faces = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
      empty_close = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < n_faces; i++) begin
         if ($urandom_range(0, 11) == 0)
            send_word($urandom, $urandom, $urandom, $urandom, 1'b0, 1'b0);
         pick_box(xmin, ymin, xmax, ymax);
         send_word(xmin, ymin, xmax, ymax, 1'b1, !empty_close && i == n_faces - 1);
         counted++;
      end
      if (empty_close) begin
         send_word($urandom, $urandom, $urandom, $urandom, 1'b0, 1'b1);
         counted++;
      end
   endtask

   // Register sets: random ones, with extremes and zero sizes for some phases.
   function automatic reg_set_t make_regs(input int kind);
      reg_set_t regs;
      regs.crop_left = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
      regs.crop_top = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
      regs.crop_width = $urandom_range(1, 65535);
      regs.crop_height = $urandom_range(1, 65535);
      regs.out_width = $urandom_range(1, 65535);
      regs.out_height = $urandom_range(1, 65535);
      regs.angle = ($urandom_range(0, 4) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
      case (kind)
         1: regs = '{16'd0, 16'd0, 16'd16, 16'd9, 16'hFFFF, 16'hFFFF, 16'd359};
         2: regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
         3: regs.crop_width = '0;
         4: regs.crop_height = '0;
         5: regs.out_width = '0;
         6: regs.out_height = '0;
         7: regs = '{16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0};
         default: ;
      endcase
      return regs;
   endfunction

   initial begin
      reg_set_t regs;
      int counted, got;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed frames with a letterboxed, downscaled crop
      regs = '{16'd100, 16'd60, 16'd1000, 16'd800, 16'd500, 16'd300, 16'd90};
      program_regs(regs);
      // frame with no face at all
      send_word(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
      // single face
      send_word(16'd300, 16'd300, 16'd499, 16'd499, 1'b1, 1'b1);
      // larger face wins, an equal one later does not, empty word closes
      send_word(16'd200, 16'd200, 16'd299, 16'd299, 1'b1, 1'b0);
      send_word(16'd400, 16'd400, 16'd599, 16'd599, 1'b1, 1'b0);
      send_word(16'd700, 16'd400, 16'd899, 16'd599, 1'b1, 1'b0);
      send_word(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
      // inverted boxes never win
      send_word(16'd500, 16'd300, 16'd400, 16'd399, 1'b1, 1'b0);
      send_word(16'd300, 16'd500, 16'd399, 16'd400, 1'b1, 1'b0);
      send_word(16'd150, 16'd120, 16'd169, 16'd139, 1'b1, 1'b1);
      // eleven growing faces: the last one is past the face limit
      for (int i = 0; i < 11; i++)
         send_word(16'd200, 16'd200, 16'(200 + 20 * (i + 1) - 1), 16'(200 + 20 * (i + 1) - 1),
                   1'b1, i == 10);
      // full-range box: clamps at the crop edge, center off the image
      send_word(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      // one-pixel box at the far corner maps to nothing
      send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      settle();

      // random frames under a series of register sets
      for (int phase = 1; phase < 14; phase++) begin
         regs = make_regs(phase);
         program_regs(regs);
         counted = 0;
         while (counted < ((phase <= 7) ? 40 : 95)) begin
            send_random_frame(got);
            counted += got;
         end
         settle();
      end

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
